// ===== rtl/rnde_pkg.sv =====
// Shared types, constants and color-distance functions for the RGB edge detector.
// No dependencies; used by the top level, rnde_window and rnde_classify by scoped names.
`timescale 1ns / 1ps

package rnde_pkg;

    // pixel, channel, distance and threshold widths
    localparam int PIX_W  = 24;
    localparam int CHAN_W = 8;
    localparam int DIST_W = 10;
    localparam int THR_W  = 10;

    // result field widths
    localparam int ROW_OUT_W = 7;
    localparam int COL_OUT_W = 8;
    localparam int TALLY_W   = 15;

    localparam logic [TALLY_W-1:0] TALLY_MAX = '1;
    localparam logic [THR_W-1:0] THR_RESET = 10'd200;

    // window geometry: nine pixels, row-major, centre in the middle
    localparam int WIN_N    = 9;
    localparam int WIN_CTR  = 4;

    // configuration register indexes
    typedef enum logic [0:0] {
        REG_THRESHOLD = 1'b0,
        REG_UNUSED    = 1'b1
    } rnde_reg_t;

    // position tag that travels with each word
    typedef struct packed {
        logic                 first;     // pixel at row 0, column 0
        logic                 emit;      // row and column both nonzero
        logic                 interior;  // row and column both at least 2
        logic                 last;      // last pixel of the frame
        logic [ROW_OUT_W-1:0] pix_row;   // row of the classified pixel
        logic [COL_OUT_W-1:0] pix_col;   // column of the classified pixel
    } rnde_tag_t;

    // 3x3 window, index = row * 3 + column
    typedef logic [WIN_N-1:0][PIX_W-1:0] rnde_win_t;

    function automatic logic [CHAN_W-1:0] chan_diff(input logic [CHAN_W-1:0] a,
                                                    input logic [CHAN_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    // sum of absolute red, green and blue differences
    function automatic logic [DIST_W-1:0] colour_dist(input logic [PIX_W-1:0] a,
                                                      input logic [PIX_W-1:0] b);
        logic [CHAN_W-1:0] d_r;
        logic [CHAN_W-1:0] d_g;
        logic [CHAN_W-1:0] d_b;
        d_r = chan_diff(a[23:16], b[23:16]);
        d_g = chan_diff(a[15:8], b[15:8]);
        d_b = chan_diff(a[7:0], b[7:0]);
        return DIST_W'(d_r) + DIST_W'(d_g) + DIST_W'(d_b);
    endfunction

endpackage

// ===== rtl/rgb_neighbor_difference_edge_detector.sv =====
// Top level of the RGB neighbor-difference edge detector: position counters,
// threshold register and the stage chain. Depends on rnde_pkg, rnde_window, rnde_classify.
//
//   channel   direction  handshake          payload
//   s_        in         s_tvalid/s_tready  tdata: red, green, blue; tuser: start_of_frame
//   m_        out        m_tvalid/m_tready  tdata: row, column, tally; tuser: is_edge; tlast
//   apb       in         psel/penable       edge_threshold at byte address 0
//
// One word per cycle sustained while m_ accepts; an input word passes the line store read,
// the window shift and the result register on its way to a result. The line stores take one
// read and one write per cycle, with forwarding when both hit the same column.
// Reset clears valid bits, counters, tally and loads the threshold with 200; line
// store contents stay unknown until written. A stall on m_ backs up through the
// stages; words at row 0 or column 0 give no result and pass the result stage freely.
`timescale 1ns / 1ps

module rgb_neighbor_difference_edge_detector #(
    parameter int IMAGE_WIDTH  = 160,
    parameter int IMAGE_HEIGHT = 120
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [7:0] red, [15:8] green, [23:16] blue
    input  logic        s_tuser,   // [0] start_of_frame
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [6:0] pixel_row, [14:7] pixel_column, [29:15] edges_so_far
    output logic        m_tuser,   // [0] is_edge
    output logic        m_tlast,   // frame_done
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int RW = $clog2(IMAGE_HEIGHT);
    localparam int CW = $clog2(IMAGE_WIDTH);

    logic [RW-1:0]                  pos_row_reg, pos_row_next;
    logic [CW-1:0]                  pos_col_reg, pos_col_next;
    logic [rnde_pkg::THR_W-1:0]     thr_reg;

    logic                           s_acc;
    logic [RW-1:0]                  cur_row;
    logic [CW-1:0]                  cur_col;
    logic [RW-1:0]                  row_m1;
    logic [CW-1:0]                  col_m1;
    rnde_pkg::rnde_tag_t            cur_tag;
    logic [rnde_pkg::PIX_W-1:0]     cur_pixel;
    rnde_pkg::rnde_reg_t            reg_sel;

    logic                           win_valid;
    logic                           win_ready;
    rnde_pkg::rnde_tag_t            win_tag;
    rnde_pkg::rnde_win_t            win_data;

    logic [rnde_pkg::ROW_OUT_W-1:0] res_row;
    logic [rnde_pkg::COL_OUT_W-1:0] res_col;
    logic                           res_edge;
    logic [rnde_pkg::TALLY_W-1:0]   res_tally;
    logic                           res_last;

    // configuration port
    assign pready  = 1'b1;
    assign reg_sel = rnde_pkg::rnde_reg_t'(paddr[2]);

    always_comb begin
        unique case (reg_sel)
            rnde_pkg::REG_THRESHOLD: prdata = 32'(thr_reg);
            default:                 prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= rnde_pkg::THR_RESET;
        end else if (psel && penable && pwrite && pready
                     && (reg_sel == rnde_pkg::REG_THRESHOLD)) begin
            thr_reg <= pwdata[rnde_pkg::THR_W-1:0];
        end
    end

    // position of the incoming word
    assign s_acc   = s_tvalid && s_tready;
    assign cur_row = s_tuser ? '0 : pos_row_reg;
    assign cur_col = s_tuser ? '0 : pos_col_reg;
    assign row_m1  = cur_row - RW'(1);
    assign col_m1  = cur_col - CW'(1);

    // raster counters with wrap at the frame edges
    always_comb begin
        pos_row_next = cur_row;
        pos_col_next = cur_col + CW'(1);
        if (cur_col == CW'(IMAGE_WIDTH - 1)) begin
            pos_col_next = '0;
            if (cur_row == RW'(IMAGE_HEIGHT - 1)) begin
                pos_row_next = '0;
            end else begin
                pos_row_next = cur_row + RW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_row_reg <= '0;
            pos_col_reg <= '0;
        end else if (s_acc) begin
            pos_row_reg <= pos_row_next;
            pos_col_reg <= pos_col_next;
        end
    end

    // tag that follows the word down the chain
    always_comb begin
        cur_tag.first    = (cur_row == '0) && (cur_col == '0);
        cur_tag.emit     = (cur_row != '0) && (cur_col != '0);
        cur_tag.interior = (cur_row >= RW'(2)) && (cur_col >= CW'(2));
        cur_tag.last     = (cur_row == RW'(IMAGE_HEIGHT - 1))
                        && (cur_col == CW'(IMAGE_WIDTH - 1));
        cur_tag.pix_row  = rnde_pkg::ROW_OUT_W'(row_m1);
        cur_tag.pix_col  = rnde_pkg::COL_OUT_W'(col_m1);
    end

    // internal pixel order: red high, blue low
    assign cur_pixel = {s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]};

    rnde_window #(
        .IMAGE_WIDTH (IMAGE_WIDTH)
    ) u_window (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_pixel   (cur_pixel),
        .in_col     (cur_col),
        .in_tag     (cur_tag),
        .out_valid  (win_valid),
        .out_ready  (win_ready),
        .out_tag    (win_tag),
        .out_window (win_data)
    );

    rnde_classify u_classify (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .threshold (thr_reg),
        .in_valid  (win_valid),
        .in_ready  (win_ready),
        .in_tag    (win_tag),
        .in_window (win_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .res_row   (res_row),
        .res_col   (res_col),
        .res_edge  (res_edge),
        .res_tally (res_tally),
        .res_last  (res_last)
    );

    // result word packing
    assign m_tdata = {2'b00, res_tally, res_col, res_row};
    assign m_tuser = res_edge;
    assign m_tlast = res_last;

endmodule

// ===== rtl/rnde_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module rnde_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 160
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port and registered read port, read returns old data on collision
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/rnde_window.sv =====
// Line stores and 3x3 window: reads the two stored rows, forwards collisions,
// shifts the window. Depends on rnde_pkg and rnde_ram.
`timescale 1ns / 1ps

module rnde_window #(
    parameter int IMAGE_WIDTH = 160
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [rnde_pkg::PIX_W-1:0]     in_pixel,
    input  logic [$clog2(IMAGE_WIDTH)-1:0] in_col,
    input  rnde_pkg::rnde_tag_t            in_tag,
    output logic                           out_valid,
    input  logic                           out_ready,
    output rnde_pkg::rnde_tag_t            out_tag,
    output rnde_pkg::rnde_win_t            out_window
);

    localparam int CW = $clog2(IMAGE_WIDTH);

    // read stage
    logic                         a_valid_reg, a_valid_next;
    logic [rnde_pkg::PIX_W-1:0]   a_px_reg;
    logic [CW-1:0]                a_col_reg;
    rnde_pkg::rnde_tag_t          a_tag_reg;
    logic                         a_byp_reg;
    logic [rnde_pkg::PIX_W-1:0]   a_byp_up_reg;
    logic [rnde_pkg::PIX_W-1:0]   a_byp_mid_reg;

    // window stage
    logic                         b_valid_reg, b_valid_next;
    rnde_pkg::rnde_tag_t          b_tag_reg;
    rnde_pkg::rnde_win_t          win_reg, win_next;

    logic                         in_acc;
    logic                         a_go;
    logic                         byp_next;
    logic [rnde_pkg::PIX_W-1:0]   up_q;
    logic [rnde_pkg::PIX_W-1:0]   mid_q;
    logic [rnde_pkg::PIX_W-1:0]   up_eff;
    logic [rnde_pkg::PIX_W-1:0]   mid_eff;

    // flow control between the two stages
    assign a_go     = a_valid_reg && (!b_valid_reg || out_ready);
    assign in_ready = !a_valid_reg || a_go;
    assign in_acc   = in_valid && in_ready;

    // a write to the address being read in the same cycle is forwarded
    assign byp_next = a_go && (in_col == a_col_reg);
    assign up_eff   = a_byp_reg ? a_byp_up_reg  : up_q;
    assign mid_eff  = a_byp_reg ? a_byp_mid_reg : mid_q;

    // upper store takes the old middle row, middle store the new pixel
    rnde_ram #(
        .WIDTH (rnde_pkg::PIX_W),
        .DEPTH (IMAGE_WIDTH)
    ) u_upper_ram (
        .aclk    (aclk),
        .wr_en   (a_go),
        .wr_addr (a_col_reg),
        .wr_data (mid_eff),
        .rd_en   (in_acc),
        .rd_addr (in_col),
        .rd_data (up_q)
    );

    rnde_ram #(
        .WIDTH (rnde_pkg::PIX_W),
        .DEPTH (IMAGE_WIDTH)
    ) u_middle_ram (
        .aclk    (aclk),
        .wr_en   (a_go),
        .wr_addr (a_col_reg),
        .wr_data (a_px_reg),
        .rd_en   (in_acc),
        .rd_addr (in_col),
        .rd_data (mid_q)
    );

    // window shift: newest column enters on the right
    always_comb begin
        win_next = win_reg;
        for (int r = 0; r < 3; r++) begin
            win_next[r*3]   = win_reg[r*3+1];
            win_next[r*3+1] = win_reg[r*3+2];
        end
        win_next[2] = up_eff;
        win_next[5] = mid_eff;
        win_next[8] = a_px_reg;
    end

    // stage valid bits
    always_comb begin
        a_valid_next = a_valid_reg;
        if (in_acc) begin
            a_valid_next = 1'b1;
        end else if (a_go) begin
            a_valid_next = 1'b0;
        end
        b_valid_next = b_valid_reg;
        if (a_go) begin
            b_valid_next = 1'b1;
        end else if (out_ready) begin
            b_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    // payload of both stages
    always_ff @(posedge aclk) begin
        if (in_acc) begin
            a_px_reg      <= in_pixel;
            a_col_reg     <= in_col;
            a_tag_reg     <= in_tag;
            a_byp_reg     <= byp_next;
            a_byp_up_reg  <= mid_eff;
            a_byp_mid_reg <= a_px_reg;
        end
        if (a_go) begin
            b_tag_reg <= a_tag_reg;
            win_reg   <= win_next;
        end
    end

    assign out_valid  = b_valid_reg;
    assign out_tag    = b_tag_reg;
    assign out_window = win_reg;

endmodule

// ===== rtl/rnde_classify.sv =====
// Edge decision over the 3x3 window, per-frame edge tally and result register.
// Depends on rnde_pkg.
`timescale 1ns / 1ps

module rnde_classify (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [rnde_pkg::THR_W-1:0]      threshold,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  rnde_pkg::rnde_tag_t             in_tag,
    input  rnde_pkg::rnde_win_t             in_window,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [rnde_pkg::ROW_OUT_W-1:0]  res_row,
    output logic [rnde_pkg::COL_OUT_W-1:0]  res_col,
    output logic                            res_edge,
    output logic [rnde_pkg::TALLY_W-1:0]    res_tally,
    output logic                            res_last
);

    logic                            m_valid_reg, m_valid_next;
    logic [rnde_pkg::ROW_OUT_W-1:0]  row_reg;
    logic [rnde_pkg::COL_OUT_W-1:0]  col_reg;
    logic                            edge_reg;
    logic [rnde_pkg::TALLY_W-1:0]    tally_reg, tally_next;
    logic [rnde_pkg::TALLY_W-1:0]    tally_out_reg;
    logic                            last_reg;

    logic                            in_go;
    logic                            emit_go;
    logic                            is_edge;
    logic [rnde_pkg::TALLY_W-1:0]    tally_base;

    // words without a result pass straight through
    assign in_ready = !in_tag.emit || !m_valid_reg || m_tready;
    assign in_go    = in_valid && in_ready;
    assign emit_go  = in_go && in_tag.emit;

    // any neighbor farther than the threshold marks an interior pixel as an edge
    always_comb begin
        is_edge = 1'b0;
        for (int k = 0; k < rnde_pkg::WIN_N; k++) begin
            if (k != rnde_pkg::WIN_CTR) begin
                if (rnde_pkg::colour_dist(in_window[k], in_window[rnde_pkg::WIN_CTR])
                        > threshold) begin
                    is_edge = 1'b1;
                end
            end
        end
        is_edge = is_edge && in_tag.interior;
    end

    // saturating tally, cleared at the first pixel of a frame
    always_comb begin
        tally_base = in_tag.first ? '0 : tally_reg;
        tally_next = tally_base;
        if (in_tag.emit && is_edge && (tally_base != rnde_pkg::TALLY_MAX)) begin
            tally_next = tally_base + rnde_pkg::TALLY_W'(1);
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (emit_go) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            tally_reg   <= '0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (in_go) begin
                tally_reg <= tally_next;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (emit_go) begin
            row_reg       <= in_tag.pix_row;
            col_reg       <= in_tag.pix_col;
            edge_reg      <= is_edge;
            tally_out_reg <= tally_next;
            last_reg      <= in_tag.last;
        end
    end

    assign m_tvalid  = m_valid_reg;
    assign res_row   = row_reg;
    assign res_col   = col_reg;
    assign res_edge  = edge_reg;
    assign res_tally = tally_out_reg;
    assign res_last  = last_reg;

endmodule

// ===== rtl/rnde_checker.sv =====
// Port-level checks for the RGB edge detector, bound to the top level.
// Depends only on the top-level port list.
`timescale 1ns / 1ps

module rnde_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [2:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("result word changed while stalled");

    // border results are never edges
    a_border: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && ((m_tdata[6:0] == 7'd0) || (m_tdata[14:7] == 8'd0)) |-> !m_tuser)
        else $error("edge flagged on a border pixel");

    // a free output side never blocks the input
    a_no_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input stalled with output ready");

    // threshold write reads back
    a_thr_readback: assert property (@(posedge aclk) disable iff (!aresetn)
        psel && penable && pwrite && (paddr[2] == 1'b0)
        |=> (paddr[2] == 1'b1) || (prdata == {22'd0, $past(pwdata[9:0])}))
        else $error("threshold readback mismatch");

    // reset empties the result register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind rgb_neighbor_difference_edge_detector rnde_checker u_rnde_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata)
);

// ===== tb/sv/tb_rgb_neighbor_difference_edge_detector.sv =====
// Self-checking bench for the RGB neighbor-difference edge detector: streams pixel
// words in, predicts each classified pixel and compares every result word.
// Depends on rnde_pkg and rgb_neighbor_difference_edge_detector.
`timescale 1ns / 1ps

module tb_rgb_neighbor_difference_edge_detector;

    localparam int IMAGE_WIDTH   = 160;
    localparam int IMAGE_HEIGHT  = 120;
    localparam int HALF_PERIOD   = 4;
    localparam int SETTLE_CYCLES = 12;
    localparam int RANDOM_ITEMS  = 220;
    localparam int HOLD_AT       = 700;
    localparam int LONG_HOLD     = 400;
    localparam int IDLE_SPAN     = 250;

    typedef struct packed {
        bit [rnde_pkg::CHAN_W-1:0] red;
        bit [rnde_pkg::CHAN_W-1:0] green;
        bit [rnde_pkg::CHAN_W-1:0] blue;
    } rgb_t;

    typedef struct packed {
        bit   sof;
        rgb_t color;
    } pixel_word_t;

    typedef struct packed {
        logic [rnde_pkg::ROW_OUT_W-1:0] row;
        logic [rnde_pkg::COL_OUT_W-1:0] column;
        logic                           is_edge;
        logic [rnde_pkg::TALLY_W-1:0]   tally;
        logic                           done;
    } edge_result_t;

    typedef enum int {
        PAT_BLOTCH,
        PAT_CHECKER
    } pattern_t;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    pixel_word_t  pixel_q[$];
    edge_result_t results_due[$];
    int           pixels_in = 0;
    int           failures  = 0;
    int           hold_left = 0;
    bit           hold_done = 1'b0;

    // shadow of the block: line stores, window, counters, tally, threshold
    rgb_t                           upper_row[IMAGE_WIDTH];
    rgb_t                           middle_row[IMAGE_WIDTH];
    rgb_t                           win[3][3];
    int                             row_at           = 0;
    int                             col_at           = 0;
    bit [rnde_pkg::TALLY_W-1:0]     tally            = '0;
    int                             threshold_shadow = int'(rnde_pkg::THR_RESET);

    rgb_neighbor_difference_edge_detector #(
        .IMAGE_WIDTH (IMAGE_WIDTH),
        .IMAGE_HEIGHT(IMAGE_HEIGHT)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),   // [7:0] red, [15:8] green, [23:16] blue
        .s_tuser (s_tuser),   // [0] start_of_frame
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),   // [6:0] pixel_row, [14:7] pixel_column, [29:15] edges_so_far
        .m_tuser (m_tuser),   // [0] is_edge
        .m_tlast (m_tlast),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // clock
    always begin
        #(HALF_PERIOD) aclk = 1'b1;
        #(HALF_PERIOD) aclk = 1'b0;
    end

    // sum of absolute channel differences
    function automatic int color_gap(input rgb_t a, input rgb_t b);
        int dr;
        int dg;
        int db;
        dr = int'(a.red) - int'(b.red);
        dg = int'(a.green) - int'(b.green);
        db = int'(a.blue) - int'(b.blue);
        return (dr < 0 ? -dr : dr) + (dg < 0 ? -dg : dg) + (db < 0 ? -db : db);
    endfunction

    // advance the shadow by one accepted pixel and queue its result, if any
    task automatic classify_pixel(input pixel_word_t w);
        rgb_t         above;
        rgb_t         mid;
        rgb_t         center;
        int           r;
        int           c;
        bit           is_edge;
        edge_result_t res;
        if (w.sof) begin
            row_at = 0;
            col_at = 0;
        end
        r = row_at;
        c = col_at;
        if (r == 0 && c == 0) tally = '0;
        above         = upper_row[c];
        mid           = middle_row[c];
        upper_row[c]  = mid;
        middle_row[c] = w.color;
        for (int k = 0; k < 3; k++) begin
            win[k][0] = win[k][1];
            win[k][1] = win[k][2];
        end
        win[0][2] = above;
        win[1][2] = mid;
        win[2][2] = w.color;
        col_at = c + 1;
        if (col_at == IMAGE_WIDTH) begin
            col_at = 0;
            row_at = (r + 1 == IMAGE_HEIGHT) ? 0 : r + 1;
        end
        if (r == 0 || c == 0) return;
        // only interior pixels can be edges
        is_edge = 1'b0;
        if (r >= 2 && c >= 2) begin
            center = win[1][1];
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    if (!(i == 1 && j == 1) && color_gap(win[i][j], center) > threshold_shadow)
                        is_edge = 1'b1;
                end
            end
        end
        if (is_edge && tally != '1) tally = tally + 1'b1;
        res.row     = rnde_pkg::ROW_OUT_W'(r - 1);
        res.column  = rnde_pkg::COL_OUT_W'(c - 1);
        res.is_edge = is_edge;
        res.tally   = tally;
        res.done    = (r == IMAGE_HEIGHT - 1 && c == IMAGE_WIDTH - 1);
        results_due.push_back(res);
    endtask

    // idle pattern rotates with the number of pixels taken in
    function automatic bit lets_through(input bit receiver);
        idle_mode_t mode;
        mode = idle_mode_t'((pixels_in / IDLE_SPAN) % 4);
        if (mode == IDLE_BOTH) return $urandom_range(99) >= 7;
        if (receiver && mode == IDLE_RECEIVER) return $urandom_range(99) >= 78;
        if (!receiver && mode == IDLE_SENDER) return $urandom_range(99) >= 78;
        return 1'b1;
    endfunction

    // pixel driver
    always @(posedge aclk) begin
        pixel_word_t w;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                classify_pixel({s_tuser, s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]});
                pixels_in <= pixels_in + 1;
            end
            if (!s_tvalid || s_tready) begin
                if (pixel_q.size() != 0 && lets_through(1'b0)) begin
                    w = pixel_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= w.sof;
                    s_tdata  <= {w.color.blue, w.color.green, w.color.red};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // one long receiver hold-off while the sender keeps going
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && pixels_in >= HOLD_AT) begin
            hold_left <= LONG_HOLD;
            hold_done <= 1'b1;
        end
    end

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endtask

    // result monitor
    always @(posedge aclk) begin
        edge_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (results_due.size() == 0) begin
                    $error("result word with none expected: row %0d column %0d",
                           m_tdata[6:0], m_tdata[14:7]);
                    failures++;
                end else begin
                    want = results_due.pop_front();
                    check_field("pixel_row", want.row, m_tdata[6:0]);
                    check_field("pixel_column", want.column, m_tdata[14:7]);
                    check_field("is_edge", want.is_edge, m_tuser);
                    check_field("edges_so_far", want.tally, m_tdata[29:15]);
                    check_field("frame_done", want.done, m_tlast);
                end
            end
            m_tready <= (hold_left == 0) && lets_through(1'b1);
        end
    end

    // block idle: nothing pending, nothing on the wire, every result back
    task automatic wait_idle();
        do @(negedge aclk);
        while (pixel_q.size() != 0 || s_tvalid || results_due.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_threshold(input int value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(4 * int'(rnde_pkg::REG_THRESHOLD));
        pwdata  <= 32'(value);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        threshold_shadow = value;
        @(negedge aclk);
    endtask

    function automatic rgb_t random_rgb();
        return {8'($urandom), 8'($urandom), 8'($urandom)};
    endfunction

    // append count pixels: smooth blotches with spikes, or a black/white checker
    task automatic queue_block(input int count, input bit sof, input rgb_t base,
                               input int amp, input pattern_t pat);
        pixel_word_t w;
        for (int i = 0; i < count; i++) begin
            w.sof = sof && (i == 0);
            if (pat == PAT_CHECKER) begin
                w.color = (((i / IMAGE_WIDTH) + (i % IMAGE_WIDTH)) % 2) ? '1 : '0;
            end else begin
                w.color.red   = base.red + 8'($urandom_range(0, amp));
                w.color.green = base.green + 8'($urandom_range(0, amp));
                w.color.blue  = base.blue + 8'($urandom_range(0, amp));
                if (amp != 0 && $urandom_range(39) == 0) w.color = random_rgb();
            end
            pixel_q.push_back(w);
        end
    endtask

    function automatic int pick_threshold();
        case ($urandom_range(7))
            0: return 0;
            1: return 764;
            2: return 765;
            3: return 1023;
            7: return $urandom_range(0, 1023);
            default: return $urandom_range(0, 500);
        endcase
    endfunction

    function automatic int pick_amp();
        case ($urandom_range(4))
            0: return 0;
            1: return 4;
            2: return 32;
            3: return 100;
            default: return 255;
        endcase
    endfunction

    // stimulus sequence
    initial begin
        int   random_items;
        int   blocks;
        int   n;
        bit   sof;
        rgb_t gray;
        random_items = 0;
        gray         = {8'd128, 8'd128, 8'd128};
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset threshold, first frame begins without a start flag
        queue_block(2 * IMAGE_WIDTH + 10, 1'b0, random_rgb(), 80, PAT_BLOTCH);

        // zero threshold: flat gray gives no edge, a one-step blue bump does
        wait_idle();
        write_threshold(0);
        queue_block(2 * IMAGE_WIDTH + 10, 1'b1, gray, 0, PAT_BLOTCH);
        pixel_q[IMAGE_WIDTH + 5].color.blue = 8'd129;

        // full-swing checker sits exactly at 765
        wait_idle();
        write_threshold(765);
        queue_block(2 * IMAGE_WIDTH + 4, 1'b1, gray, 0, PAT_CHECKER);
        wait_idle();
        write_threshold(764);
        queue_block(2 * IMAGE_WIDTH + 4, 1'b1, gray, 0, PAT_CHECKER);

        // random runs, mostly continuing the current frame, now and then restarted
        while (random_items < RANDOM_ITEMS) begin
            wait_idle();
            write_threshold(pick_threshold());
            blocks = $urandom_range(1, 2);
            for (int b = 0; b < blocks; b++) begin
                n   = $urandom_range(30, 150);
                sof = ($urandom_range(4) == 0);
                queue_block(n, sof, random_rgb(), pick_amp(), PAT_BLOTCH);
                random_items += n;
            end
        end

        wait_idle();
        if (failures == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // run limit
    initial begin
        #(2 * HALF_PERIOD * 1_000_000);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/rnde_pkg.sv
rtl/rnde_ram.sv
rtl/rnde_window.sv
rtl/rnde_classify.sv
rtl/rgb_neighbor_difference_edge_detector.sv
rtl/rnde_checker.sv
tb/sv/tb_rgb_neighbor_difference_edge_detector.sv
